FILE: rtl/dpsd_pkg.sv
// Shared types, constants and the speed factor table of the Doppler peak speed detector.
package dpsd_pkg;

	// Field widths
	localparam int unsigned MAG_W      = 16;
	localparam int unsigned PEAK_BIN_W = 9;
	localparam int unsigned SPEED_W    = 8;
	localparam int unsigned FACTOR_W   = 9;
	localparam int unsigned DVD_W      = 16;
	localparam int unsigned THR_W      = 8;
	localparam int unsigned WIN_W      = 16;
	localparam int unsigned SCL2_W     = 4;
	localparam int unsigned PSL2_W     = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 40;

	// Defaults for top-level parameters
	localparam int unsigned MAX_BINS_DEFAULT    = 512;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

	// Register reset values
	localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd160;
	localparam logic              WIN_EN_RST    = 1'b0;
	localparam logic [WIN_W-1:0]  WIN_MIN_RST   = 16'd0;
	localparam logic [WIN_W-1:0]  WIN_MAX_RST   = 16'd1024;
	localparam logic [SCL2_W-1:0] SCL2_RST      = 4'd8;
	localparam logic [PSL2_W-1:0] PSL2_RST      = 3'd7;

	// Factor used for any length/prescaler pair outside the table
	localparam logic [FACTOR_W-1:0] FACTOR_DEFAULT = 9'd100;
	// Bin to speed scale (factor is in hundredths)
	localparam logic [DVD_W-1:0]    SPEED_SCALE    = 16'd100;

	// Register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_THRESHOLD    = 3'd0,
		REG_WINDOW_ENABLE     = 3'd1,
		REG_WINDOW_MIN_BIN    = 3'd2,
		REG_WINDOW_MAX_BIN    = 3'd3,
		REG_SAMPLE_COUNT_LOG2 = 3'd4,
		REG_PRESCALER_LOG2    = 3'd5
	} cfg_reg_t;

	// Live configuration seen by the back end
	typedef struct packed {
		logic [THR_W-1:0]  peak_threshold;
		logic              window_enable;
		logic [WIN_W-1:0]  window_min_bin;
		logic [WIN_W-1:0]  window_max_bin;
		logic [SCL2_W-1:0] sample_count_log2;
		logic [PSL2_W-1:0] prescaler_log2;
	} cfg_t;

	// Per-frame summary handed from front to back
	typedef struct packed {
		logic [MAG_W-1:0]      peak_magnitude;
		logic [PEAK_BIN_W-1:0] peak_bin;
	} frame_t;

	// Factor table in hundredths: rows length 2^3..2^10, columns prescaler 2^1..2^7
	localparam logic [FACTOR_W-1:0] FACTOR_TABLE [8][7] = '{
		'{9'd5,  9'd5,  9'd5,  9'd5,  9'd5,   9'd6,   9'd7},
		'{9'd5,  9'd5,  9'd5,  9'd5,  9'd6,   9'd7,   9'd10},
		'{9'd5,  9'd6,  9'd6,  9'd6,  9'd7,   9'd11,  9'd17},
		'{9'd6,  9'd6,  9'd7,  9'd80, 9'd12,  9'd18,  9'd32},
		'{9'd7,  9'd8,  9'd10, 9'd13, 9'd20,  9'd34,  9'd63},
		'{9'd11, 9'd14, 9'd17, 9'd24, 9'd39,  9'd68,  9'd126},
		'{9'd21, 9'd24, 9'd31, 9'd46, 9'd76,  9'd135, 9'd252},
		'{9'd38, 9'd46, 9'd61, 9'd90, 9'd153, 9'd271, 9'd504}
	};

	function automatic logic [FACTOR_W-1:0] lookup_factor(
		input logic [SCL2_W-1:0] scl2,
		input logic [PSL2_W-1:0] psl2
	);
		logic [SCL2_W-1:0] row;
		logic [PSL2_W-1:0] col;
		logic [FACTOR_W-1:0] f;
		row = scl2 - 4'd3;
		col = psl2 - 3'd1;
		if (scl2 < 4'd3 || scl2 > 4'd10 || psl2 == 3'd0) begin
			f = FACTOR_DEFAULT;
		end else begin
			f = FACTOR_TABLE[row[2:0]][col];
		end
		return f;
	endfunction

endpackage

FILE: rtl/dpsd_front.sv
// Front end: accepts spectrum bins, tracks the running peak and emits one summary per frame.
module dpsd_front #(
	parameter int unsigned MAX_BINS = dpsd_pkg::MAX_BINS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dpsd_pkg::MAG_W-1:0] in_mag,
	input  logic                       in_last,
	output logic                       push,
	output dpsd_pkg::frame_t           push_data,
	input  logic                       q_full
);

	localparam int unsigned CNT_W = $clog2(MAX_BINS);
	localparam int unsigned BW    = dpsd_pkg::PEAK_BIN_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS - 1);

	logic [CNT_W-1:0]           bin_cnt_q;
	logic [dpsd_pkg::MAG_W-1:0] peak_q;
	logic [CNT_W-1:0]           peak_bin_q;

	logic                       accept;
	logic                       upd;
	logic [dpsd_pkg::MAG_W-1:0] peak_nxt;
	logic [CNT_W-1:0]           peak_bin_nxt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Compare the incoming bin against the running peak
	assign upd          = (bin_cnt_q >= CNT_W'(2)) && (in_mag > peak_q);
	assign peak_nxt     = upd ? in_mag : peak_q;
	assign peak_bin_nxt = upd ? bin_cnt_q : peak_bin_q;

	// Frame summary goes out with the last bin
	assign push                     = accept && in_last;
	assign push_data.peak_magnitude = peak_nxt;
	assign push_data.peak_bin       = BW'(peak_bin_nxt);

	// Running peak and bin counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q  <= '0;
			peak_q     <= '0;
			peak_bin_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				bin_cnt_q  <= '0;
				peak_q     <= '0;
				peak_bin_q <= '0;
			end else begin
				peak_q     <= peak_nxt;
				peak_bin_q <= peak_bin_nxt;
				if (bin_cnt_q != CNT_MAX) begin
					bin_cnt_q <= bin_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Peak bin is always a bin already seen
	a_peak_bin_seen: assert property (@(posedge clk) disable iff (!arst_n)
		peak_bin_q <= bin_cnt_q)
		else $error("peak bin ahead of bin counter");

endmodule

FILE: rtl/dpsd_queue.sv
// Short FIFO between front and back end.
module dpsd_queue #(
	parameter int unsigned WIDTH = 25,
	parameter int unsigned DEPTH = dpsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign full      = (count_q == CNT_FULL);
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count out of range");

endmodule

FILE: rtl/dpsd_back.sv
// Back end: detection checks, bin-to-speed division and the result register.
module dpsd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dpsd_pkg::cfg_t                  cfg,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  dpsd_pkg::frame_t                q_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_detected,
	output logic [dpsd_pkg::PEAK_BIN_W-1:0] out_peak_bin,
	output logic [dpsd_pkg::MAG_W-1:0]      out_peak_mag,
	output logic [dpsd_pkg::SPEED_W-1:0]    out_speed
);

	localparam int unsigned DW  = dpsd_pkg::DVD_W;
	localparam int unsigned FW  = dpsd_pkg::FACTOR_W;
	localparam int unsigned WW  = dpsd_pkg::WIN_W;
	localparam int unsigned SW  = dpsd_pkg::SPEED_W;
	localparam int unsigned IT_W = $clog2(DW);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(DW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [IT_W-1:0]                 iter_q;
	logic                            det_q;
	logic [dpsd_pkg::PEAK_BIN_W-1:0] bin_q;
	logic [dpsd_pkg::MAG_W-1:0]      mag_q;
	logic [DW-1:0]                   dvd_q;
	logic [FW-1:0]                   div_q;
	logic [FW-1:0]                   rem_q;
	logic                            out_valid_q;

	logic                            pop;
	logic                            det_thr;
	logic                            in_win;
	logic                            det;
	logic [WW-1:0]                   bin_ext;
	logic [FW:0]                     trial;
	logic                            ge;
	logic [FW:0]                     rem_nxt;
	logic                            load_out;
	logic [SW-1:0]                   speed_sat;

	assign q_ready = (state_q == ST_IDLE);
	assign pop     = q_valid && q_ready;

	// Threshold and window checks on the popped frame
	assign bin_ext = WW'(q_data.peak_bin);
	assign det_thr = q_data.peak_magnitude > dpsd_pkg::MAG_W'(cfg.peak_threshold);
	assign in_win  = (bin_ext >= cfg.window_min_bin) && (bin_ext <= cfg.window_max_bin);
	assign det     = det_thr && (!cfg.window_enable || in_win);

	// One restoring division step per cycle
	assign trial   = {rem_q, dvd_q[DW-1]};
	assign ge      = trial >= {1'b0, div_q};
	assign rem_nxt = ge ? (trial - {1'b0, div_q}) : trial;

	// Quotient saturated to the speed range
	assign speed_sat = (|dvd_q[DW-1:SW]) ? {SW{1'b1}} : dvd_q[SW-1:0];

	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						iter_q  <= '0;
						state_q <= det ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					iter_q <= iter_q + IT_W'(1);
					if (iter_q == IT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the divider
	always_ff @(posedge clk) begin
		if (pop) begin
			det_q <= det;
			bin_q <= q_data.peak_bin;
			mag_q <= q_data.peak_magnitude;
			dvd_q <= DW'(q_data.peak_bin) * dpsd_pkg::SPEED_SCALE;
			div_q <= dpsd_pkg::lookup_factor(cfg.sample_count_log2, cfg.prescaler_log2);
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_nxt[FW-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_detected <= det_q;
			out_peak_bin <= bin_q;
			out_peak_mag <= mag_q;
			out_speed    <= det_q ? speed_sat : '0;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("zero divisor in division");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_detected) |-> (out_speed == '0))
		else $error("speed set on undetected result");

endmodule

FILE: rtl/doppler_peak_speed_detector_unit.sv
// Top level of the Doppler peak speed detector: config registers, front, queue and back end.
//
// Usage:
//   s_axis carries one spectrum magnitude per transaction (tdata[15:0]), bins
//   numbered from 0 in a frame, tlast on the frame's last bin. Bins 0 and 1
//   never count as a peak. The input takes one bin per cycle while the frame queue is not full.
//   m_axis carries one result per frame: detection flag, peak bin, peak
//   magnitude and speed. A detected frame runs through the serial
//   divider (one quotient bit per cycle) before its result is registered;
//   an undetected frame skips the divider.
//   A two-entry frame queue sits between the bin tracker and the divider, so
//   bins keep flowing while a division runs; back-to-back frames shorter than
//   the divider time eventually fill the queue and stall s_axis.
//   The cfg port writes one register per transaction (index, data) and is
//   always ready; write only while no frame is in flight.
//   Reset clears the running peak, bin counter, queue and result valid flag and
//   loads the register defaults. A stall on m_axis holds the result; the
//   divider and queue then fill up before s_axis is held off.
module doppler_peak_speed_detector_unit #(
	parameter int unsigned MAX_BINS    = dpsd_pkg::MAX_BINS_DEFAULT,
	parameter int unsigned QUEUE_DEPTH = dpsd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Spectrum bins
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [dpsd_pkg::MAG_W-1:0]          s_axis_tdata,  // [15:0] magnitude
	input  logic                                s_axis_tlast,  // last_bin
	// Frame results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] detected, [9:1] peak_bin, [25:10] peak_magnitude, [33:26] speed_kmh, [39:34] zero
	output logic [dpsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// Register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dpsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned FRAME_W = $bits(dpsd_pkg::frame_t);

	dpsd_pkg::cfg_t   cfg_q;
	dpsd_pkg::frame_t push_data;
	dpsd_pkg::frame_t pop_data;
	logic [FRAME_W-1:0] pop_bits;
	logic             push;
	logic             q_full;
	logic             q_valid;
	logic             q_ready;
	logic             out_detected;
	logic [dpsd_pkg::PEAK_BIN_W-1:0] out_peak_bin;
	logic [dpsd_pkg::MAG_W-1:0]      out_peak_mag;
	logic [dpsd_pkg::SPEED_W-1:0]    out_speed;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_threshold    <= dpsd_pkg::THRESHOLD_RST;
			cfg_q.window_enable     <= dpsd_pkg::WIN_EN_RST;
			cfg_q.window_min_bin    <= dpsd_pkg::WIN_MIN_RST;
			cfg_q.window_max_bin    <= dpsd_pkg::WIN_MAX_RST;
			cfg_q.sample_count_log2 <= dpsd_pkg::SCL2_RST;
			cfg_q.prescaler_log2    <= dpsd_pkg::PSL2_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dpsd_pkg::REG_PEAK_THRESHOLD:
					cfg_q.peak_threshold <= cfg_data[dpsd_pkg::THR_W-1:0];
				dpsd_pkg::REG_WINDOW_ENABLE:
					cfg_q.window_enable <= cfg_data[0];
				dpsd_pkg::REG_WINDOW_MIN_BIN:
					cfg_q.window_min_bin <= cfg_data[dpsd_pkg::WIN_W-1:0];
				dpsd_pkg::REG_WINDOW_MAX_BIN:
					cfg_q.window_max_bin <= cfg_data[dpsd_pkg::WIN_W-1:0];
				dpsd_pkg::REG_SAMPLE_COUNT_LOG2:
					cfg_q.sample_count_log2 <= cfg_data[dpsd_pkg::SCL2_W-1:0];
				dpsd_pkg::REG_PRESCALER_LOG2:
					cfg_q.prescaler_log2 <= cfg_data[dpsd_pkg::PSL2_W-1:0];
				default: ;
			endcase
		end
	end

	// Bin tracker
	dpsd_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mag    (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	// Frame queue
	dpsd_queue #(
		.WIDTH (FRAME_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (pop_bits)
	);

	assign pop_data = dpsd_pkg::frame_t'(pop_bits);

	// Detection and speed
	dpsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (pop_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_detected (out_detected),
		.out_peak_bin (out_peak_bin),
		.out_peak_mag (out_peak_mag),
		.out_speed    (out_speed)
	);

	// Result packing, lowest field first
	assign m_axis_tdata = {6'd0, out_speed, out_peak_mag, out_peak_bin, out_detected};

endmodule

FILE: verif/doppler_peak_speed_detector_unit_tb.sv
// Testbench for the Doppler peak speed detector: random framed spectra checked against a predictor.
module doppler_peak_speed_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LAST_BIN_IDX = 511;
	localparam int unsigned SETTLE_CYCLES = 25;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned IDLE_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS = 20;
	localparam int unsigned HOLD_ITEMS = 100;

	// Indexes past the last register; writes there must change nothing
	localparam logic [dpsd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [dpsd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Speed factor in hundredths: rows length 2^3..2^10, columns prescaler 2^1..2^7
	localparam int unsigned SPEED_FACTOR [8][7] = '{
		'{ 5,  5,  5,  5,   5,   6,   7},
		'{ 5,  5,  5,  5,   6,   7,  10},
		'{ 5,  6,  6,  6,   7,  11,  17},
		'{ 6,  6,  7, 80,  12,  18,  32},
		'{ 7,  8, 10, 13,  20,  34,  63},
		'{11, 14, 17, 24,  39,  68, 126},
		'{21, 24, 31, 46,  76, 135, 252},
		'{38, 46, 61, 90, 153, 271, 504}
	};

	typedef struct packed {
		logic                            detected;
		logic [dpsd_pkg::PEAK_BIN_W-1:0] peak_bin;
		logic [dpsd_pkg::MAG_W-1:0]      peak_magnitude;
		logic [dpsd_pkg::SPEED_W-1:0]    speed_kmh;
	} frame_result_t;

	// Tracks the running peak per frame and queues the frame summaries it predicts
	class speed_scoreboard;
		logic [dpsd_pkg::THR_W-1:0]      threshold;
		logic                            win_en;
		logic [dpsd_pkg::WIN_W-1:0]      win_min;
		logic [dpsd_pkg::WIN_W-1:0]      win_max;
		logic [dpsd_pkg::SCL2_W-1:0]     len_log2;
		logic [dpsd_pkg::PSL2_W-1:0]     presc_log2;
		logic [dpsd_pkg::MAG_W-1:0]      run_peak;
		logic [dpsd_pkg::PEAK_BIN_W-1:0] run_bin;
		logic [dpsd_pkg::PEAK_BIN_W-1:0] bin_count;
		frame_result_t                   pending_frames[$];
		int unsigned                     errors;

		function new();
			threshold  = 8'd160;
			win_en     = 1'b0;
			win_min    = 16'd0;
			win_max    = 16'd1024;
			len_log2   = 4'd8;
			presc_log2 = 3'd7;
			run_peak   = '0;
			run_bin    = '0;
			bin_count  = '0;
			errors     = 0;
		endfunction

		function void write_reg(logic [dpsd_pkg::CFG_IDX_W-1:0] idx,
				logic [dpsd_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				dpsd_pkg::REG_PEAK_THRESHOLD:    threshold  = data[dpsd_pkg::THR_W-1:0];
				dpsd_pkg::REG_WINDOW_ENABLE:     win_en     = data[0];
				dpsd_pkg::REG_WINDOW_MIN_BIN:    win_min    = data[dpsd_pkg::WIN_W-1:0];
				dpsd_pkg::REG_WINDOW_MAX_BIN:    win_max    = data[dpsd_pkg::WIN_W-1:0];
				dpsd_pkg::REG_SAMPLE_COUNT_LOG2: len_log2   = data[dpsd_pkg::SCL2_W-1:0];
				dpsd_pkg::REG_PRESCALER_LOG2:    presc_log2 = data[dpsd_pkg::PSL2_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned speed_factor();
			if (len_log2 < 4'd3 || len_log2 > 4'd10 || presc_log2 == 3'd0)
				return 100;
			return SPEED_FACTOR[len_log2 - 4'd3][presc_log2 - 3'd1];
		endfunction

		// One accepted bin; the last bin of a frame closes it into a summary
		function void note_bin(logic [dpsd_pkg::MAG_W-1:0] mag, logic last);
			frame_result_t r;
			int unsigned spd;
			if (bin_count >= 2 && mag > run_peak) begin
				run_peak = mag;
				run_bin  = bin_count;
			end
			if (!last) begin
				if (bin_count != LAST_BIN_IDX[dpsd_pkg::PEAK_BIN_W-1:0])
					bin_count = bin_count + 1'b1;
				return;
			end
			r.detected = run_peak > {8'd0, threshold};
			if (r.detected && win_en)
				r.detected = {7'd0, run_bin} >= win_min && {7'd0, run_bin} <= win_max;
			spd = 0;
			if (r.detected) begin
				spd = (int'(run_bin) * 100) / speed_factor();
				if (spd > 255)
					spd = 255;
			end
			r.peak_bin       = run_bin;
			r.peak_magnitude = run_peak;
			r.speed_kmh      = spd[dpsd_pkg::SPEED_W-1:0];
			pending_frames.push_back(r);
			run_peak  = '0;
			run_bin   = '0;
			bin_count = '0;
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// One accepted result transaction against the oldest predicted frame
		function void check_result(logic [dpsd_pkg::OUT_DATA_W-1:0] data);
			frame_result_t want;
			if (pending_frames.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, data);
				errors++;
				return;
			end
			want = pending_frames.pop_front();
			check_field("detected", want.detected, data[0]);
			check_field("peak_bin", want.peak_bin, data[9:1]);
			check_field("peak_magnitude", want.peak_magnitude, data[25:10]);
			check_field("speed_kmh", want.speed_kmh, data[33:26]);
			check_field("pad bits", 0, data[39:34]);
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [dpsd_pkg::MAG_W-1:0]      s_axis_tdata;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [dpsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [dpsd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dpsd_pkg::CFG_DATA_W-1:0] cfg_data;

	speed_scoreboard sb = new();
	int unsigned hold_off_request = 0;
	int unsigned idle_cycles = 0;
	int unsigned phase_count;
	logic [dpsd_pkg::MAG_W-1:0] frame_q[$];

	doppler_peak_speed_detector_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: every handshake feeds the scoreboard; watchdog on idle cycles
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (s_axis_tvalid && s_axis_tready)
			sb.note_bin(s_axis_tdata, s_axis_tlast);
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [dpsd_pkg::MAG_W-1:0] rand_mag();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(0, 65535));
		if (r < 70)
			return 16'($urandom_range(0, 400));
		if (r < 80)
			return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		return 16'($urandom_range(0, 15));
	endfunction

	// Receiver: ready bursts and stalls, plus a long hold-off on request
	initial begin
		int unsigned run_len;
		int unsigned stall_len;
		m_axis_tready = 1'b0;
		forever begin
			if (hold_off_request != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_request) @(posedge clk);
				hold_off_request = 0;
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
			stall_len = gap_len();
			m_axis_tready <= 1'b1;
			repeat (run_len) @(posedge clk);
			if (stall_len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// One bin transaction; valid stays high across back-to-back bins
	task automatic send_bin(logic [dpsd_pkg::MAG_W-1:0] mag, logic last, bit no_gaps);
		int unsigned gap;
		gap = no_gaps ? 0 : gap_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= mag;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_frame_q(bit no_gaps);
		foreach (frame_q[i])
			send_bin(frame_q[i], i == frame_q.size() - 1, no_gaps);
	endtask

	task automatic cfg_write(logic [dpsd_pkg::CFG_IDX_W-1:0] idx,
			logic [dpsd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Stop sending and wait until every frame result is back and the back end is quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(logic [dpsd_pkg::CFG_DATA_W-1:0] thr,
			logic [dpsd_pkg::CFG_DATA_W-1:0] en,
			logic [dpsd_pkg::CFG_DATA_W-1:0] wmin, logic [dpsd_pkg::CFG_DATA_W-1:0] wmax,
			logic [dpsd_pkg::CFG_DATA_W-1:0] len_l2,
			logic [dpsd_pkg::CFG_DATA_W-1:0] presc_l2);
		cfg_write(dpsd_pkg::REG_PEAK_THRESHOLD, thr);
		cfg_write(dpsd_pkg::REG_WINDOW_ENABLE, en);
		cfg_write(dpsd_pkg::REG_WINDOW_MIN_BIN, wmin);
		cfg_write(dpsd_pkg::REG_WINDOW_MAX_BIN, wmax);
		cfg_write(dpsd_pkg::REG_SAMPLE_COUNT_LOG2, len_l2);
		cfg_write(dpsd_pkg::REG_PRESCALER_LOG2, presc_l2);
		if ($urandom_range(0, 1))
			cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
				dpsd_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random settings; upper data bits beyond a register's width are sometimes set
	task automatic program_random();
		logic [dpsd_pkg::CFG_DATA_W-1:0] junk;
		logic [dpsd_pkg::CFG_DATA_W-1:0] wmin;
		logic [dpsd_pkg::CFG_DATA_W-1:0] wmax;
		junk = $urandom_range(0, 1) ? dpsd_pkg::CFG_DATA_W'($urandom_range(0, 65535)) : '0;
		wmin = $urandom_range(0, 1) ? dpsd_pkg::CFG_DATA_W'($urandom_range(0, 600))
			: dpsd_pkg::CFG_DATA_W'($urandom_range(0, 65535));
		wmax = $urandom_range(0, 1) ? dpsd_pkg::CFG_DATA_W'($urandom_range(0, 600))
			: dpsd_pkg::CFG_DATA_W'($urandom_range(0, 65535));
		program_regs({junk[15:8], 8'($urandom_range(0, 255))}, {junk[15:1], 1'($urandom_range(0, 1))},
			wmin, wmax, {junk[15:4], 4'($urandom_range(0, 15))},
			{junk[15:3], 3'($urandom_range(0, 7))});
	endtask

	task automatic send_random_frame(bit no_gaps, output int unsigned n);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(3, 24);
		else if (r < 85)
			n = $urandom_range(25, 80);
		else if (r < 97)
			n = $urandom_range(1, 2);
		else
			n = $urandom_range(100, 400);
		for (int unsigned i = 0; i < n; i++)
			send_bin(rand_mag(), i == n - 1, no_gaps);
	endtask

	task automatic run_phase(int unsigned goal, bit no_gaps);
		int unsigned sent;
		int unsigned n;
		sent = 0;
		while (sent < goal) begin
			send_random_frame(no_gaps, n);
			sent += n;
		end
	endtask

	initial begin
		int unsigned n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset settings
		// bins 0 and 1 ignored, a later equal magnitude does not move the peak
		frame_q = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd100};
		send_frame_q(1'b0);
		// short frames: last flag on bin 0 and on bin 1
		frame_q = '{16'hFFFF};
		send_frame_q(1'b0);
		frame_q = '{16'd500, 16'd700};
		send_frame_q(1'b0);
		// peak equal to the threshold is not detected, one above is
		frame_q = '{16'd0, 16'd0, 16'd160};
		send_frame_q(1'b0);
		frame_q = '{16'd0, 16'd0, 16'd161};
		send_frame_q(1'b0);
		// all-zero frame
		frame_q = '{16'd0, 16'd0, 16'd0};
		send_frame_q(1'b0);
		// peak late in the frame
		frame_q = '{16'd3, 16'd9, 16'd200, 16'd201, 16'd50, 16'd202, 16'd1};
		send_frame_q(1'b1);
		drain();

		// Reset settings, random frames
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		// Lowest threshold, full window, smallest factor: speed saturates
		program_regs(16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd1);
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		// Highest threshold, inverted window, largest factor
		program_regs(16'd255, 16'd1, 16'd300, 16'd100, 16'd10, 16'd7);
		run_phase(PHASE_ITEMS, 1'b0);
		drain();

		// Narrow window, factor 80 entry, no idling on the sender
		program_regs(16'd160, 16'd1, 16'd5, 16'd20, 16'd6, 16'd4);
		run_phase(PHASE_ITEMS, 1'b1);
		drain();

		// Pairs outside the table; receiver holds off while short frames pile up
		program_regs(16'd20, 16'd0, 16'd0, 16'd511, 16'd0, 16'd0);
		hold_off_request = HOLD_OFF_CYCLES;
		n = 0;
		while (n < HOLD_ITEMS) begin
			frame_q.delete();
			repeat ($urandom_range(3, 6)) frame_q.push_back(rand_mag());
			n += frame_q.size();
			send_frame_q(1'b1);
		end
		drain();

		// Overlong frame: bins past the last index count as the last index
		program_regs(16'd100, 16'd1, 16'd0, 16'd511, 16'd9, 16'd2);
		frame_q.delete();
		n = $urandom_range(515, 560);
		for (int unsigned i = 0; i < n; i++)
			frame_q.push_back(i == n - 2 ? 16'hFFFF : 16'($urandom_range(0, 2000)));
		send_frame_q(1'b0);
		drain();

		// Random settings
		for (phase_count = 0; phase_count < 4; phase_count++) begin
			program_random();
			run_phase(PHASE_ITEMS, 1'b0);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/dpsd_pkg.sv
rtl/dpsd_front.sv
rtl/dpsd_queue.sv
rtl/dpsd_back.sv
rtl/doppler_peak_speed_detector_unit.sv
verif/doppler_peak_speed_detector_unit_tb.sv
